// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/str_pkg.sv
`timescale 1ns / 1ps
package str_pkg;

  localparam int MAX_SIDE = 256;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int WORD_W   = 17;
  localparam int SIDE_W   = 9;
  localparam int RAD_W    = 7;
  localparam int OFS_W    = RAD_W + 1;

  typedef enum logic [1:0] {
    OP_FILL   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_READ   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FILL,
    S_ROT,
    S_RD_ADDR,
    S_RD_DATA,
    S_DONE
  } state_t;

  // request to the shared address unit
  typedef struct packed {
    logic              quad;
    logic [1:0]        corner;
    logic [SIDE_W-1:0] top;
    logic [SIDE_W-1:0] left;
    logic [OFS_W-1:0]  last;
    logic [OFS_W-1:0]  qi;
    logic [OFS_W-1:0]  qj;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
  } addr_req_t;

endpackage

// File: src/str_item_if.sv
`timescale 1ns / 1ps
interface str_item_if;
  import str_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [SIDE_W-1:0] row;
  logic [SIDE_W-1:0] col;
  logic [RAD_W-1:0]  radius;
  logic              counter_clockwise;

  modport source (output valid, operation, row, col, radius, counter_clockwise,
                  input ready);
  modport sink (input valid, operation, row, col, radius, counter_clockwise,
                output ready);
endinterface

// File: src/str_result_if.sv
`timescale 1ns / 1ps
interface str_result_if;
  import str_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] cell_value;
  logic              status;

  modport source (output valid, cell_value, status, input ready);
  modport sink (input valid, cell_value, status, output ready);
endinterface

// File: src/square_tile_rotator_top.sv
`timescale 1ns / 1ps
// one word at a time; the next word is taken while a result waits in the output register
// fill: one store write per cycle
// rotate: r*r + r groups of four ring cells, each group read into registers and then written back
// the store's read and write ports share one address, so reads and writes take turns
// reset (sync, high) clears control and sets active_side to 256; the store is not cleared
module square_tile_rotator_top
  import str_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  str_item_if.sink          item,
  str_result_if.source      result,
  input  logic              cfg_wr_en,
  input  logic [SIDE_W-1:0] cfg_wr_data
);

  `include "assert_macros.svh"

  logic [SIDE_W-1:0] active_side;
  logic [SIDE_W-1:0] side_use;
  logic [WORD_W-1:0] rd_data;
  logic              done;
  logic [WORD_W-1:0] res_value;
  logic              res_status;
  addr_req_t         areq;
  logic [ADDR_W-1:0] addr;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic              res_free;
  logic              out_valid;
  logic [WORD_W-1:0] out_value;
  logic              out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_side <= SIDE_W'(256);
    end else if (cfg_wr_en) begin
      active_side <= cfg_wr_data;
    end
  end

  assign side_use = (32'(active_side) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : active_side;

  str_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .side       (side_use),
    .rd_data    (rd_data),
    .res_free   (res_free),
    .done       (done),
    .res_value  (res_value),
    .res_status (res_status),
    .areq       (areq),
    .ram_we     (ram_we),
    .ram_wdata  (ram_wdata)
  );

  str_addr u_addr (
    .req  (areq),
    .addr (addr)
  );

  str_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (rd_data)
  );

  // output register
  assign res_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && res_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_free) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign result.valid      = out_valid;
  assign result.cell_value = out_value;
  assign result.status     = out_status;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready)
  `ASSERT_ALWAYS(a_no_write_idle, clk, rst, !(ram_we && item.ready))
  `ASSERT_ALWAYS(a_reject_zero, clk, rst, !(out_valid && out_status) || (out_value == '0))
  `ASSERT_NEXT(a_result_loaded, clk, rst, done && res_free, out_valid)

endmodule

// File: src/str_ram.sv
`timescale 1ns / 1ps
module str_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/str_addr.sv
`timescale 1ns / 1ps
module str_addr
  import str_pkg::*;
(
  input  addr_req_t         req,
  output logic [ADDR_W-1:0] addr
);

  logic [OFS_W-1:0]  ro;
  logic [OFS_W-1:0]  co;
  logic [SIDE_W-1:0] r;
  logic [SIDE_W-1:0] c;

  // four cells of one ring position, in rotation order
  always_comb begin
    case (req.corner)
      2'd0: begin
        ro = req.qi;
        co = req.qj;
      end
      2'd1: begin
        ro = req.last - req.qj;
        co = req.qi;
      end
      2'd2: begin
        ro = req.last - req.qi;
        co = req.last - req.qj;
      end
      default: begin
        ro = req.qj;
        co = req.last - req.qi;
      end
    endcase
  end

  always_comb begin
    if (req.quad) begin
      r = req.top + SIDE_W'(ro);
      c = req.left + SIDE_W'(co);
    end else begin
      r = req.row;
      c = req.col;
    end
  end

  assign addr = ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);

endmodule

// File: src/str_ctrl.sv
`timescale 1ns / 1ps
module str_ctrl
  import str_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  str_item_if.sink          item,
  input  logic [SIDE_W-1:0] side,
  input  logic [WORD_W-1:0] rd_data,
  input  logic              res_free,
  output logic              done,
  output logic [WORD_W-1:0] res_value,
  output logic              res_status,
  output addr_req_t         areq,
  output logic              ram_we,
  output logic [WORD_W-1:0] ram_wdata
);

  localparam logic [3:0] STEP_WR0  = 4'd5;
  localparam logic [3:0] STEP_LAST = 4'd8;

  state_t            state;
  state_t            state_next;
  op_t               op;
  logic [SIDE_W-1:0] row;
  logic [SIDE_W-1:0] col;
  logic [RAD_W-1:0]  rad;
  logic              ccw;
  logic [SIDE_W-1:0] fi;
  logic [SIDE_W-1:0] fj;
  logic [WORD_W-1:0] k;
  logic [OFS_W-1:0]  qi;
  logic [OFS_W-1:0]  qj;
  logic [3:0]        step;
  logic [WORD_W-1:0] v [4];

  logic [SIDE_W-1:0] top;
  logic [SIDE_W-1:0] left;
  logic [OFS_W-1:0]  last;
  logic              rot_ok;
  logic              cell_ok;
  logic              fill_end;
  logic              ring_end;
  logic              rot_end;
  logic [3:0]        wsub;
  logic [1:0]        corner;
  logic [1:0]        src_sel;
  logic [3:0]        cap_sub;

  assign top  = row - SIDE_W'(rad) - SIDE_W'(1);
  assign left = col - SIDE_W'(rad) - SIDE_W'(1);
  assign last = {rad, 1'b0};

  assign rot_ok = (row > SIDE_W'(rad)) && (col > SIDE_W'(rad))
                  && ({1'b0, row} + (SIDE_W + 1)'(rad) <= {1'b0, side})
                  && ({1'b0, col} + (SIDE_W + 1)'(rad) <= {1'b0, side});
  assign cell_ok = (row != '0) && (row <= side) && (col != '0) && (col <= side);

  assign fill_end = (fi == side - SIDE_W'(1)) && (fj == side - SIDE_W'(1));
  assign ring_end = (qj == last - qi - OFS_W'(1));
  assign rot_end  = (step == STEP_LAST) && ring_end && (qi == OFS_W'(rad) - OFS_W'(1));

  assign wsub    = step - STEP_WR0;
  assign corner  = (step < STEP_WR0) ? step[1:0] : wsub[1:0];
  assign cap_sub = step - 4'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (op)
          OP_FILL:   state_next = (side == '0) ? S_DONE : S_FILL;
          OP_ROTATE: state_next = (rot_ok && rad != '0) ? S_ROT : S_DONE;
          OP_READ:   state_next = cell_ok ? S_RD_ADDR : S_DONE;
          default:   state_next = S_DONE;
        endcase
      end
      S_FILL: begin
        if (fill_end) begin
          state_next = S_DONE;
        end
      end
      S_ROT: begin
        if (rot_end) begin
          state_next = S_DONE;
        end
      end
      S_RD_ADDR: state_next = S_RD_DATA;
      S_RD_DATA: state_next = S_DONE;
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item.ready = 1'b0;
    done       = 1'b0;
    ram_we     = 1'b0;
    case (state)
      S_IDLE:  item.ready = 1'b1;
      S_FILL:  ram_we = 1'b1;
      S_ROT:   ram_we = (step >= STEP_WR0);
      S_DONE:  done = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    areq.quad   = (state == S_ROT);
    areq.corner = corner;
    areq.top    = top;
    areq.left   = left;
    areq.last   = last;
    areq.qi     = qi;
    areq.qj     = qj;
    if (state == S_FILL) begin
      areq.row = fi;
      areq.col = fj;
    end else begin
      areq.row = row - SIDE_W'(1);
      areq.col = col - SIDE_W'(1);
    end
  end

  // clockwise takes the next cell of the ring, counter-clockwise the previous
  assign src_sel   = ccw ? corner + 2'd3 : corner + 2'd1;
  assign ram_wdata = (state == S_FILL) ? k : v[src_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          op         <= op_t'(item.operation);
          row        <= item.row;
          col        <= item.col;
          rad        <= item.radius;
          ccw        <= item.counter_clockwise;
          res_value  <= '0;
          res_status <= 1'b0;
        end
      end
      S_CHECK: begin
        fi   <= '0;
        fj   <= '0;
        k    <= WORD_W'(1);
        qi   <= '0;
        qj   <= '0;
        step <= '0;
        case (op)
          OP_FILL:   res_status <= 1'b0;
          OP_ROTATE: res_status <= !rot_ok;
          OP_READ:   res_status <= !cell_ok;
          default:   res_status <= 1'b1;
        endcase
      end
      S_FILL: begin
        k <= k + WORD_W'(1);
        if (fj == side - SIDE_W'(1)) begin
          fj <= '0;
          fi <= fi + SIDE_W'(1);
        end else begin
          fj <= fj + SIDE_W'(1);
        end
      end
      S_ROT: begin
        if (step >= 4'd1 && step <= 4'd4) begin
          v[cap_sub[1:0]] <= rd_data;
        end
        if (step == STEP_LAST) begin
          step <= '0;
          if (ring_end) begin
            qi <= qi + OFS_W'(1);
            qj <= qi + OFS_W'(1);
          end else begin
            qj <= qj + OFS_W'(1);
          end
        end else begin
          step <= step + 4'd1;
        end
      end
      S_RD_DATA: res_value <= rd_data;
      default: ;
    endcase
  end

endmodule
